[hw/rtl/ilha_pkg.sv]
// Package with the shared types and codes of the implicit list heap allocator.
`timescale 1ns / 1ps

package ilha_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [4:0] {
        S_INIT_H,
        S_INIT_F,
        S_IDLE,
        S_DISPATCH,
        S_A_WALK,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_F_WALK,
        S_F_W0,
        S_F_W1,
        S_F_RN,
        S_F_RP,
        S_F_RPH,
        S_F_MRG,
        S_F_MW0,
        S_F_MW1,
        S_RES_OK,
        S_RES_GRANT,
        S_RES_FAIL,
        S_RES_IGN
    } state_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_INIT_HDR,
        CMD_INIT_FTR,
        CMD_LOAD,
        CMD_WALK_START,
        CMD_WALK_STEP,
        CMD_TAKE,
        CMD_WR_A0,
        CMD_WR_A1,
        CMD_WR_A2,
        CMD_WR_A3,
        CMD_WR_F0,
        CMD_WR_F1,
        CMD_RD_NXT,
        CMD_RD_PFT,
        CMD_RD_PHD,
        CMD_MERGE,
        CMD_WR_M0,
        CMD_WR_M1,
        CMD_RES_OK,
        CMD_RES_GRANT,
        CMD_RES_FAIL,
        CMD_RES_IGN
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic req_zero;
        logic ap_bad;
        logic sz_zero;
        logic fit;
        logic walk_end_alloc;
        logic is_hdr;
        logic walk_end_free;
        logic split;
    } dp_stat_t;

endpackage

[hw/rtl/ilha_dp.sv]
// Datapath of the allocator: tag memory, walk pointer and block arithmetic.
`timescale 1ns / 1ps

module ilha_dp #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ilha_pkg::dp_cmd_t  cmd,
    input  logic               op,
    input  logic [15:0]        request_bytes,
    input  logic [15:0]        payload_offset,
    output ilha_pkg::dp_stat_t stat,
    output logic [15:0]        granted_offset,
    output logic [1:0]         status
);

    localparam int TW        = $clog2(HEAP_BYTES) + 1;
    localparam int AW        = (TW + 1 > 18) ? TW + 1 : 18;
    localparam int TAG_WORDS = HEAP_BYTES / 4;
    localparam int WI        = $clog2(TAG_WORDS);
    localparam logic [AW-1:0] HEAP_END = AW'(HEAP_BYTES) & ~AW'(7);

    logic [TW-1:0] mem [TAG_WORDS];
    logic [TW-1:0] rdata_reg;

    logic          op_reg;
    logic [15:0]   req_reg;
    logic [AW-1:0] need_reg;
    logic [AW-1:0] hdr_reg;
    logic [AW-1:0] bp_reg;
    logic [AW-1:0] sz_reg;
    logic          nxt_free_reg;
    logic [AW-1:0] nsz_reg;
    logic          prv_ok_reg;
    logic [AW-1:0] prv_reg;
    logic [AW-1:0] mhdr_reg;
    logic [AW-1:0] msz_reg;
    logic [15:0]   gr_reg;
    logic [1:0]    st_reg;

    logic [AW-1:0] cur_sz;
    logic [AW-1:0] bp_next;
    logic [AW-1:0] rem;
    logic [AW-1:0] nxt;
    logic [AW-1:0] need_calc;
    logic [AW-1:0] ap_ext;
    logic          split;
    logic [AW-1:0] asz;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_data;
    logic          wr_en;
    logic          prv_free;

    assign cur_sz    = AW'(rdata_reg) & ~AW'(1);
    assign bp_next   = bp_reg + cur_sz;
    assign rem       = sz_reg - need_reg;
    assign nxt       = hdr_reg + sz_reg;
    assign split     = (rem >= AW'(16));
    assign asz       = split ? need_reg : sz_reg;
    assign need_calc = ((AW'(request_bytes) + AW'(7)) & ~AW'(7)) + AW'(8);
    assign ap_ext    = AW'(payload_offset);
    assign prv_free  = prv_ok_reg && !rdata_reg[0];

    always_comb
    begin
        stat.op             = op_reg;
        stat.req_zero       = (req_reg == 16'd0);
        stat.ap_bad         = (hdr_reg + AW'(4) < AW'(4)) || (hdr_reg + AW'(4) >= HEAP_END)
                              || (hdr_reg[2:0] != 3'd0);
        stat.sz_zero        = (cur_sz == '0);
        stat.fit            = !rdata_reg[0] && (need_reg <= cur_sz);
        stat.walk_end_alloc = (bp_next >= HEAP_END);
        stat.is_hdr         = (bp_reg == hdr_reg);
        stat.walk_end_free  = (bp_next >= HEAP_END) || (bp_next > hdr_reg);
        stat.split          = split;
    end

    always_comb
    begin
        rd_addr = bp_reg;
        wr_en   = 1'b0;
        wr_addr = hdr_reg;
        wr_data = '0;
        case (cmd)
            ilha_pkg::CMD_INIT_HDR:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = HEAP_END;
            end
            ilha_pkg::CMD_INIT_FTR:
            begin
                wr_en   = 1'b1;
                wr_addr = HEAP_END - AW'(4);
                wr_data = HEAP_END;
            end
            ilha_pkg::CMD_WALK_START: rd_addr = '0;
            ilha_pkg::CMD_WALK_STEP:  rd_addr = bp_next;
            ilha_pkg::CMD_WR_A0:
            begin
                wr_en   = 1'b1;
                wr_data = asz | AW'(1);
            end
            ilha_pkg::CMD_WR_A1:
            begin
                wr_en   = 1'b1;
                wr_addr = hdr_reg + asz - AW'(4);
                wr_data = asz | AW'(1);
            end
            ilha_pkg::CMD_WR_A2:
            begin
                wr_en   = 1'b1;
                wr_addr = hdr_reg + need_reg;
                wr_data = rem;
            end
            ilha_pkg::CMD_WR_A3:
            begin
                wr_en   = 1'b1;
                wr_addr = nxt - AW'(4);
                wr_data = rem;
            end
            ilha_pkg::CMD_WR_F0:
            begin
                wr_en   = 1'b1;
                wr_data = sz_reg;
            end
            ilha_pkg::CMD_WR_F1:
            begin
                wr_en   = 1'b1;
                wr_addr = nxt - AW'(4);
                wr_data = sz_reg;
            end
            ilha_pkg::CMD_RD_NXT: rd_addr = nxt;
            ilha_pkg::CMD_RD_PFT: rd_addr = hdr_reg - AW'(4);
            ilha_pkg::CMD_RD_PHD: rd_addr = hdr_reg - cur_sz;
            ilha_pkg::CMD_WR_M0:
            begin
                wr_en   = 1'b1;
                wr_addr = mhdr_reg;
                wr_data = msz_reg;
            end
            ilha_pkg::CMD_WR_M1:
            begin
                wr_en   = 1'b1;
                wr_addr = mhdr_reg + msz_reg - AW'(4);
                wr_data = msz_reg;
            end
            default:
            begin
                rd_addr = bp_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[WI+1:2]] <= wr_data[TW-1:0];
        end
        rdata_reg <= mem[rd_addr[WI+1:2]];
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            ilha_pkg::CMD_LOAD:
            begin
                op_reg   <= op;
                req_reg  <= request_bytes;
                need_reg <= need_calc;
                hdr_reg  <= ap_ext - AW'(4);
            end
            ilha_pkg::CMD_WALK_START: bp_reg <= '0;
            ilha_pkg::CMD_WALK_STEP:  bp_reg <= bp_next;
            ilha_pkg::CMD_TAKE:
            begin
                hdr_reg <= bp_reg;
                sz_reg  <= cur_sz;
            end
            ilha_pkg::CMD_RD_PFT:
            begin
                nxt_free_reg <= (nxt < HEAP_END) && !rdata_reg[0];
                nsz_reg      <= cur_sz;
            end
            ilha_pkg::CMD_RD_PHD:
            begin
                prv_ok_reg <= (hdr_reg != '0) && (cur_sz != '0) && (cur_sz <= hdr_reg);
                prv_reg    <= hdr_reg - cur_sz;
            end
            ilha_pkg::CMD_MERGE:
            begin
                msz_reg  <= sz_reg + (nxt_free_reg ? nsz_reg : '0)
                            + (prv_free ? cur_sz : '0);
                mhdr_reg <= prv_free ? prv_reg : hdr_reg;
            end
            default:
            begin
                bp_reg <= bp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gr_reg <= '0;
            st_reg <= ilha_pkg::ST_DONE;
        end
        else
        begin
            case (cmd)
                ilha_pkg::CMD_RES_OK:
                begin
                    gr_reg <= '0;
                    st_reg <= ilha_pkg::ST_DONE;
                end
                ilha_pkg::CMD_RES_GRANT:
                begin
                    gr_reg <= hdr_reg[15:0] + 16'd4;
                    st_reg <= ilha_pkg::ST_DONE;
                end
                ilha_pkg::CMD_RES_FAIL:
                begin
                    gr_reg <= '0;
                    st_reg <= ilha_pkg::ST_NOFIT;
                end
                ilha_pkg::CMD_RES_IGN:
                begin
                    gr_reg <= '0;
                    st_reg <= ilha_pkg::ST_IGNORED;
                end
                default:
                begin
                    gr_reg <= gr_reg;
                end
            endcase
        end
    end

    assign granted_offset = gr_reg;
    assign status         = st_reg;

endmodule

[hw/rtl/ilha_ctrl.sv]
// Controller state machine that sequences the allocator datapath.
`timescale 1ns / 1ps

module ilha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ilha_pkg::dp_stat_t stat,
    output ilha_pkg::dp_cmd_t  cmd
);

    ilha_pkg::state_t state_reg, state_next;
    logic             ov_reg, ov_next;
    logic             slot;

    assign slot      = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ilha_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilha_pkg::S_INIT_H;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ilha_pkg::S_INIT_H: state_next = ilha_pkg::S_INIT_F;
            ilha_pkg::S_INIT_F: state_next = ilha_pkg::S_IDLE;
            ilha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ilha_pkg::S_DISPATCH;
                end
            end
            ilha_pkg::S_DISPATCH:
            begin
                if (stat.op == ilha_pkg::OP_ALLOC)
                begin
                    state_next = stat.req_zero ? ilha_pkg::S_RES_FAIL : ilha_pkg::S_A_WALK;
                end
                else
                begin
                    state_next = stat.ap_bad ? ilha_pkg::S_RES_IGN : ilha_pkg::S_F_WALK;
                end
            end
            ilha_pkg::S_A_WALK:
            begin
                if (stat.sz_zero)
                begin
                    state_next = ilha_pkg::S_RES_FAIL;
                end
                else if (stat.fit)
                begin
                    state_next = ilha_pkg::S_A_W0;
                end
                else if (stat.walk_end_alloc)
                begin
                    state_next = ilha_pkg::S_RES_FAIL;
                end
            end
            ilha_pkg::S_A_W0: state_next = ilha_pkg::S_A_W1;
            ilha_pkg::S_A_W1:
            begin
                state_next = stat.split ? ilha_pkg::S_A_W2 : ilha_pkg::S_RES_GRANT;
            end
            ilha_pkg::S_A_W2: state_next = ilha_pkg::S_A_W3;
            ilha_pkg::S_A_W3: state_next = ilha_pkg::S_RES_GRANT;
            ilha_pkg::S_F_WALK:
            begin
                if (stat.is_hdr)
                begin
                    state_next = ilha_pkg::S_F_W0;
                end
                else if (stat.sz_zero || stat.walk_end_free)
                begin
                    state_next = ilha_pkg::S_RES_IGN;
                end
            end
            ilha_pkg::S_F_W0:  state_next = ilha_pkg::S_F_W1;
            ilha_pkg::S_F_W1:  state_next = ilha_pkg::S_F_RN;
            ilha_pkg::S_F_RN:  state_next = ilha_pkg::S_F_RP;
            ilha_pkg::S_F_RP:  state_next = ilha_pkg::S_F_RPH;
            ilha_pkg::S_F_RPH: state_next = ilha_pkg::S_F_MRG;
            ilha_pkg::S_F_MRG: state_next = ilha_pkg::S_F_MW0;
            ilha_pkg::S_F_MW0: state_next = ilha_pkg::S_F_MW1;
            ilha_pkg::S_F_MW1: state_next = ilha_pkg::S_RES_OK;
            ilha_pkg::S_RES_OK, ilha_pkg::S_RES_GRANT,
            ilha_pkg::S_RES_FAIL, ilha_pkg::S_RES_IGN:
            begin
                if (slot)
                begin
                    state_next = ilha_pkg::S_IDLE;
                end
            end
            default: state_next = ilha_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = ilha_pkg::CMD_NOP;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            ilha_pkg::S_INIT_H: cmd = ilha_pkg::CMD_INIT_HDR;
            ilha_pkg::S_INIT_F: cmd = ilha_pkg::CMD_INIT_FTR;
            ilha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = ilha_pkg::CMD_LOAD;
                end
            end
            ilha_pkg::S_DISPATCH:
            begin
                if (!(stat.op == ilha_pkg::OP_ALLOC ? stat.req_zero : stat.ap_bad))
                begin
                    cmd = ilha_pkg::CMD_WALK_START;
                end
            end
            ilha_pkg::S_A_WALK:
            begin
                if (!stat.sz_zero && stat.fit)
                begin
                    cmd = ilha_pkg::CMD_TAKE;
                end
                else if (!stat.sz_zero && !stat.walk_end_alloc)
                begin
                    cmd = ilha_pkg::CMD_WALK_STEP;
                end
            end
            ilha_pkg::S_A_W0: cmd = ilha_pkg::CMD_WR_A0;
            ilha_pkg::S_A_W1: cmd = ilha_pkg::CMD_WR_A1;
            ilha_pkg::S_A_W2: cmd = ilha_pkg::CMD_WR_A2;
            ilha_pkg::S_A_W3: cmd = ilha_pkg::CMD_WR_A3;
            ilha_pkg::S_F_WALK:
            begin
                if (stat.is_hdr)
                begin
                    cmd = ilha_pkg::CMD_TAKE;
                end
                else if (!stat.sz_zero && !stat.walk_end_free)
                begin
                    cmd = ilha_pkg::CMD_WALK_STEP;
                end
            end
            ilha_pkg::S_F_W0:  cmd = ilha_pkg::CMD_WR_F0;
            ilha_pkg::S_F_W1:  cmd = ilha_pkg::CMD_WR_F1;
            ilha_pkg::S_F_RN:  cmd = ilha_pkg::CMD_RD_NXT;
            ilha_pkg::S_F_RP:  cmd = ilha_pkg::CMD_RD_PFT;
            ilha_pkg::S_F_RPH: cmd = ilha_pkg::CMD_RD_PHD;
            ilha_pkg::S_F_MRG: cmd = ilha_pkg::CMD_MERGE;
            ilha_pkg::S_F_MW0: cmd = ilha_pkg::CMD_WR_M0;
            ilha_pkg::S_F_MW1: cmd = ilha_pkg::CMD_WR_M1;
            ilha_pkg::S_RES_OK:
            begin
                if (slot)
                begin
                    cmd     = ilha_pkg::CMD_RES_OK;
                    ov_next = 1'b1;
                end
            end
            ilha_pkg::S_RES_GRANT:
            begin
                if (slot)
                begin
                    cmd     = ilha_pkg::CMD_RES_GRANT;
                    ov_next = 1'b1;
                end
            end
            ilha_pkg::S_RES_FAIL:
            begin
                if (slot)
                begin
                    cmd     = ilha_pkg::CMD_RES_FAIL;
                    ov_next = 1'b1;
                end
            end
            ilha_pkg::S_RES_IGN:
            begin
                if (slot)
                begin
                    cmd     = ilha_pkg::CMD_RES_IGN;
                    ov_next = 1'b1;
                end
            end
            default: cmd = ilha_pkg::CMD_NOP;
        endcase
    end

endmodule

[hw/rtl/implicit_list_heap_allocator.sv]
// Top level of the first-fit implicit list heap allocator.
// The input channel (in_valid/in_ready) carries one transaction per request:
// op 0 allocates request_bytes, op 1 frees the block at payload_offset.
// The output channel (out_valid/out_ready) returns one transaction per request
// with granted_offset and status.
// An allocate walks the block headers from offset 0, one tag memory read per
// block, then writes the header and footer of the taken block, and those of
// the remainder too when the block is split. A failed allocate ends its walk
// without writes. A free walks the same way to check the header, then marks
// the block free, reads both neighbors and merges.
// A rejected request returns its result without a walk.
// A new request is accepted in the cycle after the previous result is loaded.
// After reset the block writes the header and footer of the single free block
// and then raises in_ready.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and processed, and its result waits until the
// output register empties.
`timescale 1ns / 1ps

module implicit_list_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] request_bytes,
    input  logic [15:0] payload_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] granted_offset,
    output logic [1:0]  status
);

    ilha_pkg::dp_cmd_t  cmd;
    ilha_pkg::dp_stat_t stat;

    ilha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ilha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .request_bytes  (request_bytes),
        .payload_offset (payload_offset),
        .stat           (stat),
        .granted_offset (granted_offset),
        .status         (status)
    );

endmodule
